// ===== design/line_segment_similarity_score_unit_macros.svh =====
// ----------------------------------------------------------------------------
// line segment similarity score unit assertion macros
// shared concurrent check forms, sampled on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_SIMILARITY_SCORE_UNIT_MACROS_SVH
`define LINE_SEGMENT_SIMILARITY_SCORE_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define LSSS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsss check failed");

// consequent holds in the cycle after the antecedent
`define LSSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsss check failed");

`endif

// ===== design/lsss_pkg.sv =====
// ----------------------------------------------------------------------------
// lsss_pkg
// widths, step counts and shared types of the line segment similarity unit
// ----------------------------------------------------------------------------
package lsss_pkg;

	// coordinate, difference, product and squared length widths
	localparam int CW = 32;
	localparam int DW = 33;
	localparam int PW = 66;
	localparam int LW = 66;
	// width of 3*|cross| and of |cross sum| for the midpoint offset
	localparam int NW = 67;
	// score width and fraction bits
	localparam int QW = 32;
	localparam int FRAC = 16;
	// perp numerator is |cs| * 2^30, i.e. two bits short of a 32-bit shift
	localparam int PERP_LOW = 2;

	// iteration counts
	localparam int LEN_ROOT_STEPS = 64;
	localparam int DIV_STEPS = 32;
	localparam int SCORE_ROOT_STEPS = 33;

	// saturated / infinite score code
	localparam logic [QW-1:0] SCORE_SAT = '1;

	// side data that rides along the length root pipeline
	typedef struct packed {
		logic [LW-1:0] ls2;
		logic [NW-1:0] rot_num;
		logic [NW-1:0] cs;
		logic          inf;
	} lsss_side_t;

endpackage

// ===== design/lsss_front.sv =====
// ----------------------------------------------------------------------------
// lsss_front
// seven stage front end: differences, lengths, reference pick, cross and dot
// products, overlap test and numerators for the divide stages
// ----------------------------------------------------------------------------
module lsss_front import lsss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] seg_a_start_x,
	input  logic signed [CW-1:0] seg_a_start_y,
	input  logic signed [CW-1:0] seg_a_end_x,
	input  logic signed [CW-1:0] seg_a_end_y,
	input  logic signed [CW-1:0] seg_b_start_x,
	input  logic signed [CW-1:0] seg_b_start_y,
	input  logic signed [CW-1:0] seg_b_end_x,
	input  logic signed [CW-1:0] seg_b_end_y,
	input  logic                 strict_mode,
	output logic                 out_valid,
	output logic [LW-1:0]        lr2,
	output lsss_side_t           side
);

	localparam int SW = NW + 1;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	// stage 1 differences
	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1;
	logic signed [DW-1:0] bax_s1, bay_s1, bex_s1, bey_s1, aex_s1, aey_s1;
	logic                 strict_s1;
	// stage 2 squares
	logic signed [DW-1:0] dax_s2, day_s2, dbx_s2, dby_s2;
	logic signed [DW-1:0] bax_s2, bay_s2, bex_s2, bey_s2, aex_s2, aey_s2;
	logic signed [PW-1:0] sqax_s2, sqay_s2, sqbx_s2, sqby_s2;
	logic                 strict_s2;
	// stage 3 reference pick
	logic signed [DW-1:0] ux_s3, uy_s3, vx_s3, vy_s3, px_s3, py_s3, qx_s3, qy_s3;
	logic [LW-1:0]        lr2_s3, ls2_s3;
	logic                 zero_s3, strict_s3;
	// stage 4 products
	logic signed [PW-1:0] uxvy_s4, uyvx_s4, pxux_s4, pyuy_s4, qxux_s4, qyuy_s4;
	logic signed [PW-1:0] uxpy_s4, uypx_s4, uxqy_s4, uyqx_s4;
	logic [LW-1:0]        lr2_s4, ls2_s4;
	logic                 zero_s4, strict_s4;
	// stage 5 sums
	logic signed [NW-1:0] cx_s5, dp_s5, dq_s5;
	logic signed [SW-1:0] cpq_s5;
	logic [LW-1:0]        lr2_s5, ls2_s5;
	logic                 zero_s5, strict_s5;
	// stage 6 magnitudes and overlap
	logic [NW-1:0]        absx_s6, cs_s6;
	logic [LW-1:0]        lr2_s6, ls2_s6;
	logic                 zero_s6, strict_s6, span_p_s6, span_q_s6;
	// stage 7 outputs
	logic [NW-1:0]        rot_num_s7, cs_s7;
	logic [LW-1:0]        lr2_s7, ls2_s7;
	logic                 inf_s7;

	// stage 3 combinational pick
	logic [LW-1:0] la2, lb2;
	logic          b_ref;

	assign la2   = LW'(sqax_s2) + LW'(sqay_s2);
	assign lb2   = LW'(sqbx_s2) + LW'(sqby_s2);
	assign b_ref = lb2 > la2;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// data path
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: segment vectors and endpoint offsets for both reference choices
			dax_s1    <= DW'(seg_a_end_x) - DW'(seg_a_start_x);
			day_s1    <= DW'(seg_a_end_y) - DW'(seg_a_start_y);
			dbx_s1    <= DW'(seg_b_end_x) - DW'(seg_b_start_x);
			dby_s1    <= DW'(seg_b_end_y) - DW'(seg_b_start_y);
			bax_s1    <= DW'(seg_b_start_x) - DW'(seg_a_start_x);
			bay_s1    <= DW'(seg_b_start_y) - DW'(seg_a_start_y);
			bex_s1    <= DW'(seg_b_end_x) - DW'(seg_a_start_x);
			bey_s1    <= DW'(seg_b_end_y) - DW'(seg_a_start_y);
			aex_s1    <= DW'(seg_a_end_x) - DW'(seg_b_start_x);
			aey_s1    <= DW'(seg_a_end_y) - DW'(seg_b_start_y);
			strict_s1 <= strict_mode;

			// s2: squared components
			sqax_s2   <= dax_s1 * dax_s1;
			sqay_s2   <= day_s1 * day_s1;
			sqbx_s2   <= dbx_s1 * dbx_s1;
			sqby_s2   <= dby_s1 * dby_s1;
			dax_s2    <= dax_s1;
			day_s2    <= day_s1;
			dbx_s2    <= dbx_s1;
			dby_s2    <= dby_s1;
			bax_s2    <= bax_s1;
			bay_s2    <= bay_s1;
			bex_s2    <= bex_s1;
			bey_s2    <= bey_s1;
			aex_s2    <= aex_s1;
			aey_s2    <= aey_s1;
			strict_s2 <= strict_s1;

			// s3: longer segment is the reference, a wins a tie
			ux_s3     <= b_ref ? dbx_s2 : dax_s2;
			uy_s3     <= b_ref ? dby_s2 : day_s2;
			vx_s3     <= b_ref ? dax_s2 : dbx_s2;
			vy_s3     <= b_ref ? day_s2 : dby_s2;
			px_s3     <= b_ref ? -bax_s2 : bax_s2;
			py_s3     <= b_ref ? -bay_s2 : bay_s2;
			qx_s3     <= b_ref ? aex_s2 : bex_s2;
			qy_s3     <= b_ref ? aey_s2 : bey_s2;
			lr2_s3    <= b_ref ? lb2 : la2;
			ls2_s3    <= b_ref ? la2 : lb2;
			zero_s3   <= b_ref ? (la2 == '0) : (lb2 == '0);
			strict_s3 <= strict_s2;

			// s4: cross and dot products
			uxvy_s4   <= ux_s3 * vy_s3;
			uyvx_s4   <= uy_s3 * vx_s3;
			pxux_s4   <= px_s3 * ux_s3;
			pyuy_s4   <= py_s3 * uy_s3;
			qxux_s4   <= qx_s3 * ux_s3;
			qyuy_s4   <= qy_s3 * uy_s3;
			uxpy_s4   <= ux_s3 * py_s3;
			uypx_s4   <= uy_s3 * px_s3;
			uxqy_s4   <= ux_s3 * qy_s3;
			uyqx_s4   <= uy_s3 * qx_s3;
			lr2_s4    <= lr2_s3;
			ls2_s4    <= ls2_s3;
			zero_s4   <= zero_s3;
			strict_s4 <= strict_s3;

			// s5: signed sums
			cx_s5     <= NW'(uxvy_s4) - NW'(uyvx_s4);
			dp_s5     <= NW'(pxux_s4) + NW'(pyuy_s4);
			dq_s5     <= NW'(qxux_s4) + NW'(qyuy_s4);
			cpq_s5    <= (SW'(uxpy_s4) - SW'(uypx_s4)) + (SW'(uxqy_s4) - SW'(uyqx_s4));
			lr2_s5    <= lr2_s4;
			ls2_s5    <= ls2_s4;
			zero_s5   <= zero_s4;
			strict_s5 <= strict_s4;

			// s6: magnitudes and projected overlap of each endpoint
			absx_s6   <= cx_s5[NW-1] ? NW'(-cx_s5) : NW'(cx_s5);
			cs_s6     <= cpq_s5[SW-1] ? NW'(-cpq_s5) : NW'(cpq_s5);
			span_p_s6 <= !dp_s5[NW-1] && ($unsigned(dp_s5) <= NW'(lr2_s5));
			span_q_s6 <= !dq_s5[NW-1] && ($unsigned(dq_s5) <= NW'(lr2_s5));
			lr2_s6    <= lr2_s5;
			ls2_s6    <= ls2_s5;
			zero_s6   <= zero_s5;
			strict_s6 <= strict_s5;

			// s7: rotation numerator and infinite flag
			rot_num_s7 <= (absx_s6 << 1) + absx_s6;
			cs_s7      <= cs_s6;
			lr2_s7     <= lr2_s6;
			ls2_s7     <= ls2_s6;
			inf_s7     <= zero_s6 || (strict_s6 && !span_p_s6 && !span_q_s6);
		end
	end

	assign out_valid    = vld_s7;
	assign lr2          = lr2_s7;
	assign side.ls2     = ls2_s7;
	assign side.rot_num = rot_num_s7;
	assign side.cs      = cs_s7;
	assign side.inf     = inf_s7;

endmodule

// ===== design/lsss_len_root.sv =====
// ----------------------------------------------------------------------------
// lsss_len_root
// pipelined floor square root of lr2 * 2^62, one result bit per stage,
// giving the reference length scaled by 2^31
// ----------------------------------------------------------------------------
module lsss_len_root import lsss_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [LW-1:0] lr2,
	input  lsss_side_t    side_in,
	output logic          out_valid,
	output logic [63:0]   len_s,
	output lsss_side_t    side_out
);

	localparam int XW = 128;
	localparam int RW = 64;
	localparam int N  = LEN_ROOT_STEPS;

	logic [XW-1:0] rem_s  [0:N];
	logic [RW-1:0] root_s [0:N];
	lsss_side_t    side_s [0:N];
	logic          vld_s  [0:N];

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= {lr2, {(XW-LW){1'b0}}};
			root_s[0] <= '0;
			side_s[0] <= side_in;
		end
	end

	// one root bit per stage, most significant first
	for (genvar g = 0; g < N; g++) begin : g_step
		localparam int B = N - 1 - g;
		logic [XW:0] trial;
		logic        take;

		assign trial = ((XW+1)'(root_s[g]) << (B + 1)) + ((XW+1)'(1) << (2 * B));
		assign take  = {1'b0, rem_s[g]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= take ? (rem_s[g] - trial[XW-1:0]) : rem_s[g];
				root_s[g+1] <= take ? (root_s[g] | (RW'(1) << B)) : root_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign len_s     = root_s[N];
	assign side_out  = side_s[N];

endmodule

// ===== design/lsss_div.sv =====
// ----------------------------------------------------------------------------
// lsss_div
// pipelined restoring divider, 32 quotient bits, one bit per stage; the
// overflow flag is set when the quotient would not fit in 32 bits
// ----------------------------------------------------------------------------
module lsss_div import lsss_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [LW-1:0] rem_init,
	input  logic [QW-1:0] low,
	input  logic [LW-1:0] den,
	input  logic          flag_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic          flag_out
);

	localparam int N = DIV_STEPS;

	logic [LW-1:0] rem_s  [0:N];
	logic [QW-1:0] low_s  [0:N];
	logic [LW-1:0] den_s  [0:N];
	logic [QW-1:0] quo_s  [0:N];
	logic          ovf_s  [0:N];
	logic          flag_s [0:N];
	logic          vld_s  [0:N];

	// entry stage: numerator high part at or above divisor means no fit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= rem_init;
			low_s[0]  <= low;
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			ovf_s[0]  <= rem_init >= den;
			flag_s[0] <= flag_in;
		end
	end

	// shift in one numerator bit, subtract when it fits
	for (genvar g = 0; g < N; g++) begin : g_step
		logic [LW:0] r2;
		logic [LW:0] diff;
		logic        take;

		assign r2   = {rem_s[g], low_s[g][QW-1]};
		assign diff = r2 - {1'b0, den_s[g]};
		assign take = r2 >= {1'b0, den_s[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= take ? diff[LW-1:0] : r2[LW-1:0];
				low_s[g+1]  <= {low_s[g][QW-2:0], 1'b0};
				den_s[g+1]  <= den_s[g];
				quo_s[g+1]  <= {quo_s[g][QW-2:0], take};
				ovf_s[g+1]  <= ovf_s[g];
				flag_s[g+1] <= flag_s[g];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign quo       = quo_s[N];
	assign ovf       = ovf_s[N];
	assign flag_out  = flag_s[N];

endmodule

// ===== design/lsss_score.sv =====
// ----------------------------------------------------------------------------
// lsss_score
// squares and adds the two terms, takes the pipelined floor root and
// saturates the result
// ----------------------------------------------------------------------------
module lsss_score import lsss_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [QW-1:0] rot_q,
	input  logic          rot_ovf,
	input  logic [QW-1:0] perp_q,
	input  logic          perp_ovf,
	input  logic          inf,
	output logic          out_valid,
	output logic [QW-1:0] score,
	output logic          is_infinite
);

	localparam int YW = 2 * QW + 2;
	localparam int RW = QW + 1;
	localparam int N  = SCORE_ROOT_STEPS;

	logic              vld_s1;
	logic [2*QW-1:0]   rsq_s1, psq_s1;
	logic              sat_s1, inf_s1;

	logic [YW-1:0] rem_s  [0:N];
	logic [RW-1:0] root_s [0:N];
	logic          sat_s  [0:N];
	logic          inf_s  [0:N];
	logic          vld_s  [0:N];

	// squares, then sum of squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsq_s1    <= rot_q * rot_q;
			psq_s1    <= perp_q * perp_q;
			sat_s1    <= rot_ovf || perp_ovf;
			inf_s1    <= inf;
			rem_s[0]  <= YW'(rsq_s1) + YW'(psq_s1);
			root_s[0] <= '0;
			sat_s[0]  <= sat_s1;
			inf_s[0]  <= inf_s1;
		end
	end

	// one root bit per stage
	for (genvar g = 0; g < N; g++) begin : g_step
		localparam int B = N - 1 - g;
		logic [YW:0] trial;
		logic        take;

		assign trial = ((YW+1)'(root_s[g]) << (B + 1)) + ((YW+1)'(1) << (2 * B));
		assign take  = {1'b0, rem_s[g]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= take ? (rem_s[g] - trial[YW-1:0]) : rem_s[g];
				root_s[g+1] <= take ? (root_s[g] | (RW'(1) << B)) : root_s[g];
				sat_s[g+1]  <= sat_s[g];
				inf_s[g+1]  <= inf_s[g];
			end
		end
	end

	// saturate on infinite, term overflow or root at full scale
	assign out_valid   = vld_s[N];
	assign is_infinite = inf_s[N];
	assign score       = (inf_s[N] || sat_s[N] || (root_s[N] >= RW'(SCORE_SAT)))
		? SCORE_SAT : root_s[N][QW-1:0];

endmodule

// ===== design/line_segment_similarity_score_unit.sv =====
// ----------------------------------------------------------------------------
// line segment similarity score unit
// dissimilarity score of two 2-D segments, fully pipelined
// ----------------------------------------------------------------------------
// Takes one segment pair per clock while seg_stall is low. The pipeline
// holds the 64-step root that finds the reference length, the two 32-step
// dividers for the rotation and offset terms and the 33-step root of the
// final score; each of these retires one bit per stage. A two-entry output
// buffer holds results while the consumer stalls; seg_stall rises once its
// second entry is in use and the whole pipeline then holds.
`include "line_segment_similarity_score_unit_macros.svh"

module line_segment_similarity_score_unit import lsss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 seg_valid,
	output logic                 seg_stall,
	input  logic signed [CW-1:0] seg_a_start_x,
	input  logic signed [CW-1:0] seg_a_start_y,
	input  logic signed [CW-1:0] seg_a_end_x,
	input  logic signed [CW-1:0] seg_a_end_y,
	input  logic signed [CW-1:0] seg_b_start_x,
	input  logic signed [CW-1:0] seg_b_start_y,
	input  logic signed [CW-1:0] seg_b_end_x,
	input  logic signed [CW-1:0] seg_b_end_y,
	input  logic                 strict_mode,
	output logic                 score_valid,
	input  logic                 score_stall,
	output logic [QW-1:0]        score,
	output logic                 is_infinite
);

	logic          en;
	logic          fe_valid, lr_valid, rd_valid, pd_valid, res_valid;
	logic [LW-1:0] fe_lr2;
	lsss_side_t    fe_side, lr_side;
	logic [63:0]   len_s;
	logic [QW-1:0] rot_q, perp_q, res_score;
	logic          rot_ovf, perp_ovf, rot_inf, res_inf;

	logic          out_v_q, skid_v_q;
	logic [QW-1:0] out_score_q, skid_score_q;
	logic          out_inf_q, skid_inf_q;
	logic          take_in, out_free;

	// whole pipeline advances unless the skid entry is full
	assign en        = !skid_v_q;
	assign seg_stall = skid_v_q;

	lsss_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (seg_valid),
		.seg_a_start_x (seg_a_start_x),
		.seg_a_start_y (seg_a_start_y),
		.seg_a_end_x   (seg_a_end_x),
		.seg_a_end_y   (seg_a_end_y),
		.seg_b_start_x (seg_b_start_x),
		.seg_b_start_y (seg_b_start_y),
		.seg_b_end_x   (seg_b_end_x),
		.seg_b_end_y   (seg_b_end_y),
		.strict_mode   (strict_mode),
		.out_valid     (fe_valid),
		.lr2           (fe_lr2),
		.side          (fe_side)
	);

	lsss_len_root u_len_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fe_valid),
		.lr2       (fe_lr2),
		.side_in   (fe_side),
		.out_valid (lr_valid),
		.len_s     (len_s),
		.side_out  (lr_side)
	);

	// rotation term: 3*|cross| * 2^16 / ls2
	lsss_div u_rot_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (lr_valid),
		.rem_init  (LW'(lr_side.rot_num >> FRAC)),
		.low       ({lr_side.rot_num[FRAC-1:0], {(QW-FRAC){1'b0}}}),
		.den       (lr_side.ls2),
		.flag_in   (lr_side.inf),
		.out_valid (rd_valid),
		.quo       (rot_q),
		.ovf       (rot_ovf),
		.flag_out  (rot_inf)
	);

	// midpoint offset term: |cs| * 2^30 / len_s
	lsss_div u_perp_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (lr_valid),
		.rem_init  (LW'(lr_side.cs >> PERP_LOW)),
		.low       ({lr_side.cs[PERP_LOW-1:0], {(QW-PERP_LOW){1'b0}}}),
		.den       (LW'(len_s)),
		.flag_in   (1'b0),
		.out_valid (pd_valid),
		.quo       (perp_q),
		.ovf       (perp_ovf),
		.flag_out  ()
	);

	lsss_score u_score (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (rd_valid),
		.rot_q       (rot_q),
		.rot_ovf     (rot_ovf),
		.perp_q      (perp_q),
		.perp_ovf    (perp_ovf),
		.inf         (rot_inf),
		.out_valid   (res_valid),
		.score       (res_score),
		.is_infinite (res_inf)
	);

	// output buffer: main register plus one skid entry
	assign take_in  = en && res_valid;
	assign out_free = !out_v_q || !score_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= take_in;
			end
		end else if (take_in) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_score_q <= skid_score_q;
				out_inf_q   <= skid_inf_q;
			end else if (take_in) begin
				out_score_q <= res_score;
				out_inf_q   <= res_inf;
			end
		end else if (take_in) begin
			skid_score_q <= res_score;
			skid_inf_q   <= res_inf;
		end
	end

	assign score_valid = out_v_q;
	assign score       = out_score_q;
	assign is_infinite = out_inf_q;

	// checks
	`LSSS_ASSERT_NOW(a_skid_needs_out, skid_v_q, out_v_q)
	`LSSS_ASSERT_NOW(a_inf_saturates, out_v_q && out_inf_q, out_score_q == SCORE_SAT)
	`LSSS_ASSERT_NEXT(a_blocked_beat_kept, take_in && out_v_q && score_stall, skid_v_q)

	// pipeline valid bits stay in step across the two dividers
	`LSSS_ASSERT_NOW(a_div_aligned, 1'b1, rd_valid == pd_valid)

endmodule

// ===== bench/tb_line_segment_similarity_score_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line segment similarity score unit testbench
// drives segment pairs in random bursts against a stalling consumer and checks
// every score beat against a wide-integer predictor of the dissimilarity score
// ----------------------------------------------------------------------------
module tb_line_segment_similarity_score_unit;
	import lsss_pkg::*;

	localparam int NUM_RANDOM = 1730;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 400;

	typedef logic signed [139:0] wide_t;
	typedef logic [139:0] uwide_t;

	typedef struct {
		logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		logic strict;
	} seg_pair_t;

	typedef struct {
		logic [QW-1:0] score;
		logic inf;
	} score_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seg_valid = 1'b0;
	logic seg_stall;
	logic signed [CW-1:0] seg_a_start_x = '0, seg_a_start_y = '0, seg_a_end_x = '0;
	logic signed [CW-1:0] seg_a_end_y = '0, seg_b_start_x = '0, seg_b_start_y = '0;
	logic signed [CW-1:0] seg_b_end_x = '0, seg_b_end_y = '0;
	logic strict_mode = 1'b0;
	logic score_valid;
	logic score_stall = 1'b0;
	logic [QW-1:0] score;
	logic is_infinite;

	seg_pair_t pending_pairs[$];
	score_beat_t expected_scores[$];
	int errors = 0;
	int cycles = 0;
	int pairs_sent = 0;
	int scores_seen = 0;
	int inf_seen = 0;
	int sat_seen = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;

	line_segment_similarity_score_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_stall(seg_stall),
		.seg_a_start_x(seg_a_start_x), .seg_a_start_y(seg_a_start_y),
		.seg_a_end_x(seg_a_end_x), .seg_a_end_y(seg_a_end_y),
		.seg_b_start_x(seg_b_start_x), .seg_b_start_y(seg_b_start_y),
		.seg_b_end_x(seg_b_end_x), .seg_b_end_y(seg_b_end_y),
		.strict_mode(strict_mode),
		.score_valid(score_valid), .score_stall(score_stall),
		.score(score), .is_infinite(is_infinite)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor square root, 64-bit result
	function automatic uwide_t floor_root(input uwide_t x);
		uwide_t r, t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (uwide_t'(1) << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	function automatic wide_t abs_w(input wide_t x);
		return (x < 0) ? -x : x;
	endfunction

	// expected dissimilarity score of one segment pair
	function automatic score_beat_t predict_score(input seg_pair_t p);
		score_beat_t res;
		wide_t dax, day, dbx, dby, la2, lb2, lr2, ls2;
		wide_t ux, uy, vx, vy, px, py, qx, qy, dp, dq, cr, cs, rot, perp;
		uwide_t s, root;
		logic b_ref;
		dax = wide_t'(p.ax1) - wide_t'(p.ax0);
		day = wide_t'(p.ay1) - wide_t'(p.ay0);
		dbx = wide_t'(p.bx1) - wide_t'(p.bx0);
		dby = wide_t'(p.by1) - wide_t'(p.by0);
		la2 = dax * dax + day * day;
		lb2 = dbx * dby * 0 + dbx * dbx + dby * dby;
		b_ref = lb2 > la2;
		// longer segment is the reference, ties go to A
		if (b_ref) begin
			lr2 = lb2; ls2 = la2; ux = dbx; uy = dby; vx = dax; vy = day;
			px = wide_t'(p.ax0) - wide_t'(p.bx0); py = wide_t'(p.ay0) - wide_t'(p.by0);
			qx = wide_t'(p.ax1) - wide_t'(p.bx0); qy = wide_t'(p.ay1) - wide_t'(p.by0);
		end else begin
			lr2 = la2; ls2 = lb2; ux = dax; uy = day; vx = dbx; vy = dby;
			px = wide_t'(p.bx0) - wide_t'(p.ax0); py = wide_t'(p.by0) - wide_t'(p.ay0);
			qx = wide_t'(p.bx1) - wide_t'(p.ax0); qy = wide_t'(p.by1) - wide_t'(p.ay0);
		end
		res.inf = (ls2 == 0);
		// strict overlap of projected endpoints
		if (!res.inf && p.strict) begin
			dp = px * ux + py * uy;
			dq = qx * ux + qy * uy;
			if (!(dp >= 0 && dp <= lr2) && !(dq >= 0 && dq <= lr2))
				res.inf = 1'b1;
		end
		res.score = SCORE_SAT;
		if (!res.inf) begin
			cr = abs_w(ux * vy - uy * vx);
			rot = ((cr * 3) <<< FRAC) / ls2;
			cs = abs_w((ux * py - uy * px) + (ux * qy - uy * qx));
			s = floor_root(uwide_t'(lr2) << 62);
			perp = (cs <<< 30) / wide_t'(s);
			if (rot <= wide_t'(SCORE_SAT) && perp <= wide_t'(SCORE_SAT)) begin
				root = floor_root(uwide_t'(rot * rot + perp * perp));
				if (root < uwide_t'(SCORE_SAT))
					res.score = root[QW-1:0];
			end
		end
		return res;
	endfunction

	task automatic add_pair(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1,
			input logic strict);
		seg_pair_t p;
		p.ax0 = ax0; p.ay0 = ay0; p.ax1 = ax1; p.ay1 = ay1;
		p.bx0 = bx0; p.by0 = by0; p.bx1 = bx1; p.by1 = by1;
		p.strict = strict;
		pending_pairs.push_back(p);
	endtask

	function automatic int rand_span(input int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	// random pair, mostly well-formed nearby segments
	task automatic add_random_pair();
		int kind, r, ax0, ay0, ax1, ay1, j, dx, dy;
		logic strict;
		kind = $urandom_range(0, 9);
		strict = $urandom_range(0, 1);
		r = 1 << $urandom_range(4, 26);
		ax0 = rand_span(r); ay0 = rand_span(r);
		ax1 = rand_span(r); ay1 = rand_span(r);
		j = 1 << $urandom_range(0, 20);
		if (kind < 2) begin
			// full 32-bit noise
			add_pair($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, strict);
		end else if (kind < 6) begin
			// jittered copy of A, sometimes reversed
			if ($urandom_range(0, 1))
				add_pair(ax0, ay0, ax1, ay1, ax0 + rand_span(j), ay0 + rand_span(j),
					ax1 + rand_span(j), ay1 + rand_span(j), strict);
			else
				add_pair(ax0, ay0, ax1, ay1, ax1 + rand_span(j), ay1 + rand_span(j),
					ax0 + rand_span(j), ay0 + rand_span(j), strict);
		end else if (kind < 9) begin
			// short B somewhere along or beside A, may be degenerate
			dx = ($urandom_range(0, 15) == 0) ? 0 : rand_span(j);
			dy = (dx == 0) ? 0 : rand_span(j);
			ax0 = ax0 + rand_span(r);
			add_pair(ax0 - rand_span(r), ay0, ax1, ay1, ax0, ay0 + rand_span(j),
				ax0 + dx, ay0 + dy, strict);
		end else begin
			add_pair(ax0, ay0, ax1, ay1, rand_span(r), rand_span(r),
				rand_span(r), rand_span(r), strict);
		end
	endtask

	// sender: bursts with gaps, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid <= 1'b0;
		end else if (!seg_valid || !seg_stall) begin
			if (seg_valid) begin
				expected_scores.push_back(predict_score(pending_pairs.pop_front()));
				pairs_sent++;
			end
			if (gap_left > 0) begin
				gap_left--;
				seg_valid <= 1'b0;
			end else if (pending_pairs.size() > 0) begin
				seg_valid <= 1'b1;
				seg_a_start_x <= pending_pairs[0].ax0;
				seg_a_start_y <= pending_pairs[0].ay0;
				seg_a_end_x <= pending_pairs[0].ax1;
				seg_a_end_y <= pending_pairs[0].ay1;
				seg_b_start_x <= pending_pairs[0].bx0;
				seg_b_start_y <= pending_pairs[0].by0;
				seg_b_end_x <= pending_pairs[0].bx1;
				seg_b_end_y <= pending_pairs[0].by1;
				strict_mode <= pending_pairs[0].strict;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 60);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
				end
			end else begin
				seg_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, in one of four randomly chosen modes: none, light, heavy or periodic
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_stall <= 1'b0;
		end else begin
			cycles++;
			if (cycles % 512 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: score_stall <= 1'b0;
				1: score_stall <= ($urandom_range(0, 9) < 3);
				2: score_stall <= ($urandom_range(0, 9) < 8);
				default: score_stall <= ((cycles % 7) < 3);
			endcase
		end
	end

	// score checker
	always @(posedge clk) begin
		if (arst_n && score_valid && !score_stall) begin
			scores_seen++;
			if (is_infinite) inf_seen++;
			else if (score == SCORE_SAT) sat_seen++;
			if (expected_scores.size() == 0) begin
				errors++;
				$display("%0t: unexpected score beat score=%h inf=%b", $time, score,
					is_infinite);
			end else begin
				score_beat_t e;
				e = expected_scores.pop_front();
				if (score !== e.score || is_infinite !== e.inf) begin
					errors++;
					$display("%0t: mismatch expected score=%h inf=%b, actual score=%h inf=%b",
						$time, e.score, e.inf, score, is_infinite);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d pairs sent, %0d scores seen", $time, pairs_sent,
				scores_seen);
			$display("[line_segment_similarity_score_unit] ERROR");
			$finish;
		end
	end

	localparam int ONE = 65536;

	initial begin
		// directed: extremes, degenerate, overlap cases, saturation
		add_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		add_pair(0, 0, ONE, 0, 5, 5, 5, 5, 1'b1);
		add_pair(0, 0, 4 * ONE, 0, ONE, ONE, 2 * ONE, ONE, 1'b1);
		add_pair(0, 0, 4 * ONE, 0, ONE, ONE, 2 * ONE, 2 * ONE, 1'b0);
		add_pair(0, 0, 4 * ONE, 0, -ONE, ONE, 5 * ONE, ONE, 1'b1);
		add_pair(0, 0, ONE, 0, -2 * ONE, ONE, 4 * ONE, ONE, 1'b1);
		add_pair(0, 0, ONE, 0, 3 * ONE, 0, 4 * ONE, 0, 1'b1);
		add_pair(0, 0, ONE, 0, 3 * ONE, 0, 4 * ONE, 0, 1'b0);
		add_pair(0, 0, ONE, 0, -4 * ONE, 0, -3 * ONE, 0, 1'b1);
		add_pair(0, 0, 2 * ONE, 0, 0, 0, 0, 2 * ONE, 1'b1);
		add_pair(0, 0, 2 * ONE, 0, 2 * ONE, 0, 2 * ONE, 2 * ONE, 1'b1);
		add_pair(ONE, ONE, 3 * ONE, 3 * ONE, 0, 0, 10 * ONE, 10 * ONE, 1'b1);
		add_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			0, 0, 1, 0, 1'b0);
		add_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		add_pair(0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1'b0);
		add_pair(0, 0, 1, 0, 0, 0, 0, 1, 1'b0);
		add_pair(0, 0, 1, 1, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 1'b0);
		add_pair(-1, -1, 32'hFFFF_0000, -1, -1, 32'hFFFF_0000, 0, 0, 1'b1);
		add_pair(ONE, 0, 0, 0, 0, ONE, ONE, ONE, 1'b1);
		for (int i = 0; i < NUM_RANDOM; i++)
			add_random_pair();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_pairs.size() == 0 && !seg_valid);
		wait (expected_scores.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d pairs: %0d scores, %0d infinite, %0d saturated", pairs_sent,
			scores_seen, inf_seen, sat_seen);
		$display("directed extremes and degenerate cases, then random bursts under stall");
		if (errors == 0 && expected_scores.size() == 0)
			$display("[line_segment_similarity_score_unit] OK");
		else
			$display("[line_segment_similarity_score_unit] ERROR");
		$finish;
	end

endmodule
